// File: design/hgp_pkg.sv
// Shared types, codes and small decode functions for the GET request parser.
`default_nettype none
package hgp_pkg;

  // Result field widths
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned PATH_W  = 10;

  // Default limits
  localparam int unsigned URI_MAX_DEF     = 512;
  localparam int unsigned VERSION_MAX_DEF = 16;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_UNIT   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DONE   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_UNSUP  = 2'd2;
  localparam logic [EVENT_W-1:0] EV_CLOSED = 2'd3;

  // Byte codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // One result between the step logic and the output register
  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [UNIT_W-1:0]  code_unit;
    logic [PATH_W-1:0]  path_length;
  } result_t;

  // Expected method letters, G E T
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit value; anything else counts as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) v = b[3:0] + 4'd9;
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/http_get_request_parser.sv
// HTTP GET request parser top level: input register, step logic, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte of the client
//   request per transfer, with conn_closed_i marking a closed connection.
//   Output channel (out_valid_o / out_stall_i) carries events: a decoded
//   path code unit, request complete with path length, unsupported request,
//   or connection closed. A byte yields zero or one event.
//   Flow: a byte is taken into the input register, decoded by the step logic
//   and its event written to the result register, which drives the output.
//   Throughput: one byte per cycle when not stalled; the per-byte state update
//   is a single combinational pass between the input and result registers.
//   Stall: while out_stall_i holds a pending event, the byte in the input
//   register waits and in_stall_o rises; the byte behind it is still taken
//   as long as the input register is free or drains in the same cycle.
//   Reset: rst_ni (asynchronous, active low) empties both registers and puts
//   the parser back to awaiting the method of a new request.
`default_nettype none
module http_get_request_parser #(
  parameter int unsigned URI_MAX     = hgp_pkg::URI_MAX_DEF,
  parameter int unsigned VERSION_MAX = hgp_pkg::VERSION_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          conn_closed_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [hgp_pkg::EVENT_W-1:0]        event_res_o,
  output logic [hgp_pkg::UNIT_W-1:0]         code_unit_o,
  output logic [hgp_pkg::PATH_W-1:0]         path_length_o
);
  import hgp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       closed_q;
  logic       adv;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // Process the held byte when the result register is free or draining
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q   <= data_byte_i;
      closed_q <= conn_closed_i;
    end
  end

  hgp_step #(
    .URI_MAX     (URI_MAX),
    .VERSION_MAX (VERSION_MAX)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .data_byte_i   (byte_q),
    .conn_closed_i (closed_q),
    .res_valid_o   (res_valid),
    .result_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_q.event_res;
  assign code_unit_o   = out_q.code_unit;
  assign path_length_o = out_q.path_length;

endmodule
`default_nettype wire

// File: design/hgp_step.sv
// Parser state registers and the per-byte next-state and result logic.
`default_nettype none
module hgp_step #(
  parameter int unsigned URI_MAX     = hgp_pkg::URI_MAX_DEF,
  parameter int unsigned VERSION_MAX = hgp_pkg::VERSION_MAX_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            conn_closed_i,
  output logic                 res_valid_o,
  output hgp_pkg::result_t     result_o
);
  import hgp_pkg::*;

  localparam int unsigned UW = $clog2(URI_MAX + 1);
  localparam int unsigned VW = $clog2(VERSION_MAX + 1);

  localparam logic [1:0] PH_METHOD  = 2'd0;
  localparam logic [1:0] PH_URI     = 2'd1;
  localparam logic [1:0] PH_VERSION = 2'd2;
  localparam logic [1:0] PH_HEADER  = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic [1:0]    method_count_q, method_count_d;
  logic          method_ok_q, method_ok_d;
  logic [1:0]    hex_left_q, hex_left_d;
  logic [7:0]    hex_value_q, hex_value_d;
  logic [1:0]    utf_left_q, utf_left_d;
  logic [15:0]   utf_accum_q, utf_accum_d;
  logic [UW-1:0] uri_bytes_q, uri_bytes_d;
  logic [UW-1:0] units_out_q, units_out_d;
  logic [VW-1:0] version_count_q, version_count_d;
  logic [7:0]    prev_byte_q, prev_byte_d;
  logic [1:0]    line_length_q, line_length_d;

  // Decode one byte against the current state
  always_comb begin
    logic       take;
    logic [7:0] tb;
    logic       clr;
    logic [7:0] hv;
    take            = 1'b0;
    tb              = data_byte_i;
    clr             = 1'b0;
    hv              = {hex_value_q[3:0], hex_digit(data_byte_i)};
    phase_d         = phase_q;
    method_count_d  = method_count_q;
    method_ok_d     = method_ok_q;
    hex_left_d      = hex_left_q;
    hex_value_d     = hex_value_q;
    utf_left_d      = utf_left_q;
    utf_accum_d     = utf_accum_q;
    uri_bytes_d     = uri_bytes_q;
    units_out_d     = units_out_q;
    version_count_d = version_count_q;
    prev_byte_d     = prev_byte_q;
    line_length_d   = line_length_q;
    res_valid_o     = 1'b0;
    result_o        = '0;

    if (conn_closed_i) begin
      clr                = 1'b1;
      res_valid_o        = 1'b1;
      result_o.event_res = EV_CLOSED;
    end else begin
      case (phase_q)
        PH_METHOD: begin
          if (method_count_q != 2'd3) begin
            if (data_byte_i != method_char(method_count_q)) method_ok_d = 1'b0;
            method_count_d = method_count_q + 2'd1;
          end else if (!method_ok_q) begin
            clr                = 1'b1;
            res_valid_o        = 1'b1;
            result_o.event_res = EV_UNSUP;
          end else begin
            method_count_d = 2'd0;
            phase_d        = PH_URI;
          end
        end
        PH_URI: begin
          if (hex_left_q != 2'd0) begin
            hex_value_d = hv;
            hex_left_d  = hex_left_q - 2'd1;
            if (hex_left_q == 2'd1) begin
              take = 1'b1;
              tb   = hv;
            end
          end else if (data_byte_i == CH_SPACE) begin
            utf_left_d      = 2'd0;
            utf_accum_d     = 16'd0;
            version_count_d = '0;
            prev_byte_d     = 8'd0;
            phase_d         = PH_VERSION;
          end else if (data_byte_i == CH_PERCENT) begin
            hex_left_d  = 2'd2;
            hex_value_d = 8'd0;
          end else begin
            take = 1'b1;
          end
        end
        PH_VERSION: begin
          if (data_byte_i == CH_LF) begin
            if (prev_byte_q != CH_CR) begin
              clr                = 1'b1;
              res_valid_o        = 1'b1;
              result_o.event_res = EV_UNSUP;
            end else begin
              line_length_d = 2'd0;
              phase_d       = PH_HEADER;
            end
          end else if (version_count_q >= VW'(VERSION_MAX)) begin
            clr                = 1'b1;
            res_valid_o        = 1'b1;
            result_o.event_res = EV_UNSUP;
          end else begin
            version_count_d = version_count_q + VW'(1);
            prev_byte_d     = data_byte_i;
          end
        end
        PH_HEADER: begin
          if (data_byte_i == CH_LF) begin
            if (line_length_q == 2'd1) begin
              clr                  = 1'b1;
              res_valid_o          = 1'b1;
              result_o.event_res   = EV_DONE;
              result_o.path_length = PATH_W'(units_out_q);
            end else begin
              line_length_d = 2'd0;
            end
          end else if (line_length_q != 2'd2) begin
            line_length_d = line_length_q + 2'd1;
          end
        end
        default: clr = 1'b1;
      endcase
    end

    // Feed one decoded URI byte into the UTF-8 decoder
    if (take) begin
      if (uri_bytes_q >= UW'(URI_MAX)) begin
        clr                = 1'b1;
        res_valid_o        = 1'b1;
        result_o.event_res = EV_UNSUP;
      end else begin
        uri_bytes_d = uri_bytes_q + UW'(1);
        if (utf_left_q != 2'd0) begin
          utf_accum_d = {utf_accum_q[9:0], tb[5:0]};
          utf_left_d  = utf_left_q - 2'd1;
          if (utf_left_q == 2'd1) begin
            units_out_d        = units_out_q + UW'(1);
            res_valid_o        = 1'b1;
            result_o.event_res = EV_UNIT;
            result_o.code_unit = {utf_accum_q[9:0], tb[5:0]};
          end
        end else if (!tb[7]) begin
          utf_accum_d        = {8'd0, tb};
          units_out_d        = units_out_q + UW'(1);
          res_valid_o        = 1'b1;
          result_o.event_res = EV_UNIT;
          result_o.code_unit = {8'd0, tb};
        end else if (tb[7:5] == 3'b110) begin
          utf_accum_d = {11'd0, tb[4:0]};
          utf_left_d  = 2'd1;
        end else if (tb[7:4] == 4'b1110) begin
          utf_accum_d = {11'd0, tb[4:0]};
          utf_left_d  = 2'd2;
        end
      end
    end

    // Return to await a new request
    if (clr) begin
      phase_d         = PH_METHOD;
      method_count_d  = 2'd0;
      method_ok_d     = 1'b1;
      hex_left_d      = 2'd0;
      hex_value_d     = 8'd0;
      utf_left_d      = 2'd0;
      utf_accum_d     = 16'd0;
      uri_bytes_d     = '0;
      units_out_d     = '0;
      version_count_d = '0;
      prev_byte_d     = 8'd0;
      line_length_d   = 2'd0;
    end
  end

  // Update state once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_METHOD;
      method_count_q  <= 2'd0;
      method_ok_q     <= 1'b1;
      hex_left_q      <= 2'd0;
      hex_value_q     <= 8'd0;
      utf_left_q      <= 2'd0;
      utf_accum_q     <= 16'd0;
      uri_bytes_q     <= '0;
      units_out_q     <= '0;
      version_count_q <= '0;
      prev_byte_q     <= 8'd0;
      line_length_q   <= 2'd0;
    end else if (adv_i) begin
      phase_q         <= phase_d;
      method_count_q  <= method_count_d;
      method_ok_q     <= method_ok_d;
      hex_left_q      <= hex_left_d;
      hex_value_q     <= hex_value_d;
      utf_left_q      <= utf_left_d;
      utf_accum_q     <= utf_accum_d;
      uri_bytes_q     <= uri_bytes_d;
      units_out_q     <= units_out_d;
      version_count_q <= version_count_d;
      prev_byte_q     <= prev_byte_d;
      line_length_q   <= line_length_d;
    end
  end

endmodule
`default_nettype wire

// File: design/hgp_checker.sv
// Port-level assertions for the GET request parser, bound to the top level.
`default_nettype none
module hgp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [hgp_pkg::EVENT_W-1:0]   event_res_o,
  input wire logic [hgp_pkg::UNIT_W-1:0]    code_unit_o,
  input wire logic [hgp_pkg::PATH_W-1:0]    path_length_o
);
  import hgp_pkg::*;

  // Hold a stalled event and its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o)
      && $stable(code_unit_o) && $stable(path_length_o))
    else $error("stalled output event changed");

  // Never stall the input while the result register is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // Code unit is zero on every non-unit event
  a_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_UNIT |-> code_unit_o == '0)
    else $error("code unit set on non-unit event");

  // Path length is zero unless the request completed
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_DONE |-> path_length_o == '0)
    else $error("path length set on non-complete event");

  // Come out of reset with no event pending
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("event pending after reset");

endmodule

bind http_get_request_parser hgp_checker u_hgp_checker (.*);
`default_nettype wire

// File: sim/http_get_request_parser_test.sv
// Self-checking testbench for the HTTP GET request parser: byte stream in, path events out.
`timescale 1ns / 100ps
module http_get_request_parser_test;
  import hgp_pkg::*;

  localparam int unsigned URI_LIMIT      = URI_MAX_DEF;
  localparam int unsigned VERSION_LIMIT  = VERSION_MAX_DEF;
  localparam int unsigned ITEM_GOAL      = 1250;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [23:0] GET_TEXT       = "GET";

  // Request flaws picked per generated request; other draws give a clean request
  localparam int FLAW_METHOD       = 0;
  localparam int FLAW_NO_CR        = 1;
  localparam int FLAW_LONG_VERSION = 2;
  localparam int FLAW_CLOSE        = 3;
  localparam int FLAW_NOISE        = 4;
  localparam int FLAW_RANGE        = 19;

  typedef enum logic [1:0] {P_METHOD, P_URI, P_VERSION, P_HEADER} parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       closed;
  } client_byte_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic [7:0]           data_byte_i   = 8'h00;
  logic                 conn_closed_i = 1'b0;
  logic                 out_stall_i   = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [EVENT_W-1:0]   event_res_o;
  logic [UNIT_W-1:0]    code_unit_o;
  logic [PATH_W-1:0]    path_length_o;

  http_get_request_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .conn_closed_i (conn_closed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .code_unit_o   (code_unit_o),
    .path_length_o (path_length_o)
  );

  // Run the clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  wire byte_taken  = in_valid_i && !in_stall_o;
  wire event_taken = out_valid_o && !out_stall_i;

  client_byte_t bytes_to_send[$];
  result_t      expected_events[$];
  int unsigned  fails = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  // Parser state mirror
  parse_phase_e ph;
  logic [1:0]   meth_cnt;
  logic         meth_ok;
  logic [1:0]   hex_left;
  logic [7:0]   hex_val;
  logic [1:0]   utf_left;
  logic [15:0]  utf_acc;
  logic [9:0]   uri_cnt;
  logic [9:0]   units_cnt;
  logic [4:0]   ver_cnt;
  logic [7:0]   last_byte;
  logic [1:0]   line_len;

  function automatic void restart_parser();
    ph        = P_METHOD;
    meth_cnt  = 2'd0;
    meth_ok   = 1'b1;
    hex_left  = 2'd0;
    hex_val   = 8'h00;
    utf_left  = 2'd0;
    utf_acc   = 16'h0000;
    uri_cnt   = '0;
    units_cnt = '0;
    ver_cnt   = '0;
    last_byte = 8'h00;
    line_len  = 2'd0;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  function automatic void reject_request(output bit hit, output result_t r);
    restart_parser();
    hit = 1'b1;
    r = '0;
    r.event_res = EV_UNSUP;
  endfunction

  // Feed one decoded URI byte through the UTF-8 decoder
  function automatic void feed_uri(input logic [7:0] d, output bit hit, output result_t r);
    hit = 1'b0;
    r = '0;
    if (uri_cnt >= URI_LIMIT) begin
      reject_request(hit, r);
      return;
    end
    uri_cnt++;
    if (utf_left != 2'd0) begin
      utf_acc = {utf_acc[9:0], d[5:0]};
      utf_left--;
      if (utf_left != 2'd0) return;
    end else if (!d[7]) begin
      utf_acc = {8'h00, d};
    end else if (d[7:5] == 3'b110) begin
      utf_acc = {11'd0, d[4:0]};
      utf_left = 2'd1;
      return;
    end else if (d[7:4] == 4'b1110) begin
      utf_acc = {11'd0, d[4:0]};
      utf_left = 2'd2;
      return;
    end else begin
      // drop stray continuations and 4-byte or invalid leads
      return;
    end
    units_cnt++;
    hit = 1'b1;
    r.event_res = EV_UNIT;
    r.code_unit = utf_acc;
  endfunction

  // Advance the mirror by one accepted byte and give the event it causes
  function automatic void parse_byte(input logic [7:0] b, input logic closed,
                                     output bit hit, output result_t r);
    hit = 1'b0;
    r = '0;
    if (closed) begin
      restart_parser();
      hit = 1'b1;
      r.event_res = EV_CLOSED;
      return;
    end
    case (ph)
      P_METHOD: begin
        if (meth_cnt < 2'd3) begin
          if (b != GET_TEXT[23 - 8 * meth_cnt -: 8]) meth_ok = 1'b0;
          meth_cnt++;
        end else if (!meth_ok) begin
          reject_request(hit, r);
        end else begin
          meth_cnt = 2'd0;
          ph = P_URI;
        end
      end
      P_URI: begin
        if (hex_left != 2'd0) begin
          hex_val = {hex_val[3:0], nibble_of(b)};
          hex_left--;
          if (hex_left == 2'd0) feed_uri(hex_val, hit, r);
        end else if (b == CH_SPACE) begin
          utf_left = 2'd0;
          utf_acc = 16'h0000;
          ver_cnt = '0;
          last_byte = 8'h00;
          ph = P_VERSION;
        end else if (b == CH_PERCENT) begin
          hex_left = 2'd2;
          hex_val = 8'h00;
        end else begin
          feed_uri(b, hit, r);
        end
      end
      P_VERSION: begin
        if (b == CH_LF) begin
          if (last_byte != CH_CR) begin
            reject_request(hit, r);
          end else begin
            line_len = 2'd0;
            ph = P_HEADER;
          end
        end else if (ver_cnt >= VERSION_LIMIT) begin
          reject_request(hit, r);
        end else begin
          ver_cnt++;
          last_byte = b;
        end
      end
      default: begin
        if (b == CH_LF) begin
          if (line_len == 2'd1) begin
            hit = 1'b1;
            r.event_res = EV_DONE;
            r.path_length = units_cnt;
            restart_parser();
          end else begin
            line_len = 2'd0;
          end
        end else if (line_len < 2'd2) begin
          line_len++;
        end
      end
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic void note_failure(input string msg);
    fails++;
    if (fails <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // Stimulus builders
  function automatic void push_byte(input logic [7:0] b);
    bytes_to_send.push_back('{data: b, closed: 1'b0});
  endfunction

  function automatic void push_close();
    bytes_to_send.push_back('{data: 8'($urandom), closed: 1'b1});
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // Printable byte that neither ends the URI nor starts an escape
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == CH_PERCENT) c = "/";
    return c;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] c;
    c = 8'h80 | 8'($urandom_range(0, 63));
    // now and then break the top bits of a continuation
    if ($urandom_range(0, 3) == 0) c = 8'($urandom);
    if (c == CH_SPACE || c == CH_PERCENT) c = 8'hBF;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    int mode;
    mode = $urandom_range(0, 7);
    if (mode == 0) return 8'($urandom);
    if (v < 4'd10) return "0" + 8'(v);
    return ((mode < 4) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  function automatic void put_escape(ref logic [7:0] q[$], input logic [7:0] v);
    q.push_back(CH_PERCENT);
    q.push_back(hex_char(v[7:4]));
    q.push_back(hex_char(v[3:0]));
  endfunction

  // Build one request: mostly well formed, with a random flaw now and then
  task automatic add_request();
    logic [7:0] req[$];
    int flaw;
    int n;
    int cut;
    logic [7:0] b;
    flaw = $urandom_range(0, FLAW_RANGE);
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 3) == 0) push_close();
        else push_byte(8'($urandom));
      end
      return;
    end
    req = '{8'h47, 8'h45, 8'h54, ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_SPACE};
    if (flaw == FLAW_METHOD) req[$urandom_range(0, 2)] = 8'($urandom);

    // URI
    n = $urandom_range(0, 10);
    repeat (n) begin
      case ($urandom_range(0, 9))
        4: put_escape(req, 8'($urandom));
        5: begin
          req.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          req.push_back(cont_byte());
        end
        6: begin
          req.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          req.push_back(cont_byte());
          req.push_back(cont_byte());
        end
        7: begin
          if ($urandom_range(0, 1) == 0) begin
            put_escape(req, 8'hC0 | 8'($urandom_range(0, 31)));
          end else begin
            put_escape(req, 8'hE0 | 8'($urandom_range(0, 15)));
            put_escape(req, 8'h80 | 8'($urandom_range(0, 63)));
          end
          put_escape(req, 8'h80 | 8'($urandom_range(0, 63)));
        end
        8: req.push_back(8'($urandom_range(8'h80, 8'hFF)));
        9: begin
          req.push_back(8'hF0 | 8'($urandom_range(0, 15)));
          repeat (3) req.push_back(cont_byte());
        end
        default: req.push_back(plain_char());
      endcase
    end
    req.push_back(CH_SPACE);

    // version line
    n = (flaw == FLAW_LONG_VERSION) ? $urandom_range(VERSION_LIMIT, VERSION_LIMIT + 4)
                                    : $urandom_range(0, VERSION_LIMIT - 1);
    repeat (n) req.push_back(plain_char());
    if (flaw != FLAW_NO_CR) req.push_back(CH_CR);
    req.push_back(CH_LF);

    // header lines, then the one-byte line that ends the request
    repeat ($urandom_range(0, 3)) begin
      n = $urandom_range(0, 10);
      if (n == 1) n = 0;
      repeat (n) req.push_back(plain_char());
      req.push_back(CH_LF);
    end
    b = CH_CR;
    if ($urandom_range(0, 3) == 0) b = plain_char();
    req.push_back(b);
    req.push_back(CH_LF);

    cut = req.size();
    if (flaw == FLAW_CLOSE) cut = $urandom_range(0, req.size() - 1);
    for (int i = 0; i < cut; i++) push_byte(req[i]);
    if (flaw == FLAW_CLOSE) push_close();
  endtask

  // Drive request bytes, predict the event of each accepted one
  bit           pred_hit;
  result_t      pred_res;
  client_byte_t next_byte;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (byte_taken) begin
        parse_byte(data_byte_i, conn_closed_i, pred_hit, pred_res);
        if (pred_hit) expected_events.push_back(pred_res);
        bytes_taken++;
        if (bytes_taken % 200 == 0) calm <= ~calm;
      end
      if (!in_valid_i || byte_taken) begin
        if (send_gap > 0 || bytes_to_send.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          next_byte = bytes_to_send.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= next_byte.data;
          conn_closed_i <= next_byte.closed;
          send_gap = draw_wait();
        end
      end
    end
  end

  // Check events against the oldest expectation, stall at random
  result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (event_taken) begin
        if (expected_events.size() == 0) begin
          note_failure($sformatf("unexpected event %0d unit %h length %0d",
                                 event_res_o, code_unit_o, path_length_o));
        end else begin
          want = expected_events.pop_front();
          if (event_res_o !== want.event_res || code_unit_o !== want.code_unit ||
              path_length_o !== want.path_length) begin
            note_failure($sformatf(
              "expected event %0d unit %h length %0d, got event %0d unit %h length %0d",
              want.event_res, want.code_unit, want.path_length,
              event_res_o, code_unit_o, path_length_o));
          end
        end
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if (byte_taken || event_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    restart_parser();

    // 4th method byte ignored, escape with non-hex digit giving a stray byte
    push_text("GETx%a%");
    // 3-byte lead with odd continuations, then a partial unit cut by the space
    push_byte(8'hE2); push_byte(8'h00); push_byte(8'hFF); push_byte(8'hC3);
    push_byte(CH_SPACE);
    // LF as the first version byte
    push_byte(CH_LF);
    // close in the middle of an escape
    push_text("GET /%2");
    push_close();
    // shortest complete request
    push_text("GET a ");
    push_byte(CH_CR); push_byte(CH_LF); push_byte(CH_CR); push_byte(CH_LF);

    // URI one byte past the limit
    push_text("GET ");
    repeat (URI_LIMIT + 1) push_byte(plain_char());

    while (bytes_to_send.size() < ITEM_GOAL) add_request();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain everything, then let trailing events show up
    while (bytes_to_send.size() != 0 || in_valid_i || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0 && expected_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hgp_pkg.sv
design/hgp_step.sv
design/http_get_request_parser.sv
design/hgp_checker.sv
sim/http_get_request_parser_test.sv
